/* rtl/core/tdr_pkg.sv */
// Shared types, codes and the control program of the thick DDA line rasteriser.
// Used by the top level and the testbench; depends on nothing else.
`default_nettype none

package tdr_pkg;

  // Width of the line_width configuration register.
  localparam int WIDTH_BITS = 6;

  // Operation codes carried by an input request.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Step counter of the sequencer and the address of each step of the program.
  typedef logic [1:0] step_t;
  localparam step_t STEP_WAIT   = 2'd0;
  localparam step_t STEP_SETUP  = 2'd1;
  localparam step_t STEP_DIVIDE = 2'd2;
  localparam step_t STEP_FINISH = 2'd3;

  // Datapath operation selected by a control word.
  typedef enum logic [1:0] {
    UOP_WAIT,
    UOP_SETUP,
    UOP_DIVIDE,
    UOP_FINISH
  } uop_t;

  // Jump condition of a control word; when it holds the step counter loads the
  // target, otherwise it moves on to the following step.
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NO_START,
    COND_ZERO_LEN,
    COND_DIV_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    logic  take;
    cond_t cond;
    step_t target;
  } ucw_t;

  // The control program: wait for requests, set a line up, run the slope
  // division one quotient bit a step, then fix the sign of the slope.
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    case (s)
      STEP_WAIT:   w = '{uop: UOP_WAIT,   take: 1'b1, cond: COND_NO_START, target: STEP_WAIT};
      STEP_SETUP:  w = '{uop: UOP_SETUP,  take: 1'b0, cond: COND_ZERO_LEN, target: STEP_WAIT};
      STEP_DIVIDE: w = '{uop: UOP_DIVIDE, take: 1'b0, cond: COND_DIV_BUSY, target: STEP_DIVIDE};
      STEP_FINISH: w = '{uop: UOP_FINISH, take: 1'b0, cond: COND_ALWAYS,   target: STEP_WAIT};
      default:     w = '{uop: UOP_WAIT,   take: 1'b0, cond: COND_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tdr_chan_if.sv */
// Valid/ready channel interfaces of the thick DDA line rasteriser: the request
// channel and the pixel channel. No dependencies.
`default_nettype none

interface tdr_in_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tdr_out_if #(parameter int COORD_BITS = 12);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic                       line_done;

  modport source (output valid, pixel_x, pixel_y, line_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, line_done, output ready);
endinterface

`default_nettype wire

/* rtl/core/thick_dda_line_rasterizer.sv */
// Thick DDA line rasteriser. An advance request accepted on an active line puts its
// pixel in the output register on the next cycle; advances stream at one a cycle
// while the pixel channel is not stalled. A start request holds the request channel
// through setup, the restoring slope divider (FRACTION_BITS+1 quotient bits) and the
// sign fix, or only through setup when the endpoints coincide. Synchronous
// active-low reset: idle, no line active, line width one.
`default_nettype none

module thick_dda_line_rasterizer #(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tdr_in_if.sink                              in_chan,
  tdr_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [tdr_pkg::WIDTH_BITS-1:0] cfg_wdata
);

  localparam int CB    = COORD_BITS;
  localparam int FB    = FRACTION_BITS;
  localparam int ACC_W = CB + FB;
  localparam int CNT_W = $clog2(FB + 1);
  localparam int WB    = tdr_pkg::WIDTH_BITS;
  localparam int OFS_W = WB + 1;

  tdr_pkg::step_t step_r, step_nxt;
  tdr_pkg::ucw_t  ucw;

  logic signed [CB-1:0]    x0_r, y0_r, x1_r, y1_r;
  logic signed [CB-1:0]    x0_nxt, y0_nxt, x1_nxt, y1_nxt;
  logic                    active_r, active_nxt;
  logic                    steep_r, steep_nxt;
  logic signed [CB-1:0]    maj_pos_r, maj_pos_nxt;
  logic signed [CB-1:0]    maj_end_r, maj_end_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] inc_r, inc_nxt;
  logic [WB-1:0]           span_r, span_nxt;
  logic [WB-1:0]           width_r, width_nxt;
  logic [CB:0]             rem_r, rem_nxt;
  logic [CB-1:0]           div_r, div_nxt;
  logic [FB:0]             quo_r, quo_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [CB:0]      out_x_r, out_x_nxt;
  logic signed [CB:0]      out_y_r, out_y_nxt;
  logic                    out_done_r, out_done_nxt;

  // Setup datapath.
  logic signed [CB:0]   dx, dy, dmin;
  logic [CB:0]          adx_full, ady_full, admin_full;
  logic [CB-1:0]        adx, ady, admin;
  logic                 zero_len, steep, swap;
  logic signed [CB-1:0] maj_a, maj_b, min_a, min_b;
  logic signed [CB-1:0] maj_lo, maj_hi, min_lo, min_hi;

  // Divider step.
  logic          div_ge;
  logic [CB:0]   rem_sub;
  logic [ACC_W-1:0] quo_ext;

  // Pixel datapath.
  logic [WB-1:0]      eff_w;
  logic [OFS_W-1:0]   offset;
  logic               last_span, done;
  logic [CB-1:0]      minor;
  logic               round_up;
  logic signed [CB:0] minor_ext, offset_ext, minor_pix, major_pix;

  logic in_fire, start_fire, emit, out_free, cond_hit;

  assign ucw      = tdr_pkg::ucode(step_r);
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready = ucw.take && out_free;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign start_fire    = in_fire && (in_chan.operation == tdr_pkg::OP_START);
  assign emit          = in_fire && (in_chan.operation == tdr_pkg::OP_ADVANCE) && active_r;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pixel_x   = out_x_r;
  assign out_chan.pixel_y   = out_y_r;
  assign out_chan.line_done = out_done_r;

  // Line setup from the latched endpoints.
  always_comb begin
    dx       = {x1_r[CB-1], x1_r} - {x0_r[CB-1], x0_r};
    dy       = {y1_r[CB-1], y1_r} - {y0_r[CB-1], y0_r};
    adx_full = dx[CB] ? -dx : dx;
    ady_full = dy[CB] ? -dy : dy;
    adx      = adx_full[CB-1:0];
    ady      = ady_full[CB-1:0];
    zero_len = (adx == '0) && (ady == '0);
    steep    = ady >= adx;
    maj_a    = steep ? y0_r : x0_r;
    maj_b    = steep ? y1_r : x1_r;
    min_a    = steep ? x0_r : y0_r;
    min_b    = steep ? x1_r : y1_r;
    swap     = maj_b < maj_a;
    maj_lo   = swap ? maj_b : maj_a;
    maj_hi   = swap ? maj_a : maj_b;
    min_lo   = swap ? min_b : min_a;
    min_hi   = swap ? min_a : min_b;
    dmin     = {min_hi[CB-1], min_hi} - {min_lo[CB-1], min_lo};
    admin_full = dmin[CB] ? -dmin : dmin;
    admin    = admin_full[CB-1:0];
  end

  // Restoring divider: compare, subtract, then shift the remainder left.
  always_comb begin
    div_ge  = rem_r >= {1'b0, div_r};
    rem_sub = div_ge ? (rem_r - {1'b0, div_r}) : rem_r;
    quo_ext = {{(ACC_W-FB-1){1'b0}}, quo_r};
  end

  // Pixel of the current span; the minor coordinate truncates toward zero.
  always_comb begin
    eff_w      = (width_r == '0) ? WB'(1) : width_r;
    offset     = {1'b0, span_r} - {1'b0, eff_w >> 1};
    last_span  = ({1'b0, span_r} + OFS_W'(1)) >= {1'b0, eff_w};
    done       = last_span && (maj_pos_r == maj_end_r);
    round_up   = acc_r[ACC_W-1] && (acc_r[FB-1:0] != '0);
    minor      = acc_r[ACC_W-1:FB] + {{(CB-1){1'b0}}, round_up};
    minor_ext  = {minor[CB-1], minor};
    offset_ext = {{(CB+1-OFS_W){offset[OFS_W-1]}}, offset};
    minor_pix  = minor_ext + offset_ext;
    major_pix  = {maj_pos_r[CB-1], maj_pos_r};
  end

  always_comb begin
    case (ucw.cond)
      tdr_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      tdr_pkg::COND_NO_START: cond_hit = !start_fire;
      tdr_pkg::COND_ZERO_LEN: cond_hit = zero_len;
      tdr_pkg::COND_DIV_BUSY: cond_hit = cnt_r != '0;
      default:                cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? ucw.target : tdr_pkg::step_t'(step_r + 2'd1);
  end

  always_comb begin
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    active_nxt    = active_r;
    steep_nxt     = steep_r;
    maj_pos_nxt   = maj_pos_r;
    maj_end_nxt   = maj_end_r;
    acc_nxt       = acc_r;
    inc_nxt       = inc_r;
    span_nxt      = span_r;
    width_nxt     = cfg_we ? cfg_wdata : width_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_done_nxt  = out_done_r;

    case (ucw.uop)
      tdr_pkg::UOP_WAIT: begin
        if (start_fire) begin
          // A new start drops any line in progress.
          x0_nxt     = in_chan.start_x;
          y0_nxt     = in_chan.start_y;
          x1_nxt     = in_chan.end_x;
          y1_nxt     = in_chan.end_y;
          active_nxt = 1'b0;
          span_nxt   = '0;
        end else if (emit) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = steep_r ? minor_pix : major_pix;
          out_y_nxt     = steep_r ? major_pix : minor_pix;
          out_done_nxt  = done;
          if (last_span) begin
            span_nxt = '0;
            if (done) begin
              active_nxt = 1'b0;
            end else begin
              maj_pos_nxt = maj_pos_r + CB'(1);
              acc_nxt     = acc_r + inc_r;
            end
          end else begin
            span_nxt = span_r + WB'(1);
          end
        end
      end
      tdr_pkg::UOP_SETUP: begin
        steep_nxt   = steep;
        maj_pos_nxt = maj_lo;
        maj_end_nxt = maj_hi;
        acc_nxt     = {min_lo, {FB{1'b0}}};
        rem_nxt     = {1'b0, admin};
        div_nxt     = steep ? ady : adx;
        neg_nxt     = dmin[CB];
        cnt_nxt     = CNT_W'(FB);
      end
      tdr_pkg::UOP_DIVIDE: begin
        quo_nxt = {quo_r[FB-1:0], div_ge};
        rem_nxt = {rem_sub[CB-1:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      tdr_pkg::UOP_FINISH: begin
        inc_nxt    = neg_r ? -quo_ext : quo_ext;
        active_nxt = 1'b1;
      end
      default: begin
        active_nxt = active_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= tdr_pkg::STEP_WAIT;
      active_r    <= 1'b0;
      span_r      <= '0;
      width_r     <= WB'(1);
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      active_r    <= active_nxt;
      span_r      <= span_nxt;
      width_r     <= width_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    steep_r    <= steep_nxt;
    maj_pos_r  <= maj_pos_nxt;
    maj_end_r  <= maj_end_nxt;
    acc_r      <= acc_nxt;
    inc_r      <= inc_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_done_r <= out_done_nxt;
  end

endmodule

`default_nettype wire

/* dv/tb_thick_dda_line_rasterizer.sv */
`timescale 1ns / 1ps
// Testbench of the thick DDA line rasteriser: directed and random requests with random stalls on
// both channels, checked against a line-drawing predictor kept in a small scoreboard class.
// Depends on tdr_pkg, the channel interfaces in tdr_chan_if.sv and thick_dda_line_rasterizer.

module tb_thick_dda_line_rasterizer;

  localparam int COORD_BITS    = 12;
  localparam int FRACTION_BITS = 16;
  localparam int SETTLE_CYCLES = FRACTION_BITS + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_ADVANCES  = 200;
  localparam longint FIX_ONE   = longint'(1) << FRACTION_BITS;

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [COORD_BITS:0]     pix_t;
  typedef logic [tdr_pkg::WIDTH_BITS-1:0] width_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    pix_t x;
    pix_t y;
    logic done;
  } pixel_t;

  class raster_scoreboard;
    bit          line_active;
    bit          steep_axis;
    longint      major_pos;
    longint      major_end;
    longint      minor_acc;
    longint      minor_inc;
    int unsigned span_index;
    width_t      line_width;
    pixel_t      expected_pixels[$];
    int          mismatches;

    function void reset_state();
      line_active = 1'b0;
      steep_axis  = 1'b0;
      major_pos   = 0;
      major_end   = 0;
      minor_acc   = 0;
      minor_inc   = 0;
      span_index  = 0;
      line_width  = width_t'(1);
      expected_pixels.delete();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    // Applies one accepted request; returns 1 when it produces a pixel.
    function bit take_request(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      longint      dx, dy, adx, ady, maj0, maj1, min0, min1, hold, minor, offset, px, py;
      int unsigned w;
      bit          last_span;
      pixel_t      pix;
      if (op == tdr_pkg::OP_START) begin
        dx  = longint'(ex) - longint'(sx);
        dy  = longint'(ey) - longint'(sy);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        span_index = 0;
        if (adx == 0 && ady == 0) begin
          line_active = 1'b0;
          return 1'b0;
        end
        steep_axis = (ady >= adx);
        if (steep_axis) begin
          maj0 = longint'(sy); maj1 = longint'(ey); min0 = longint'(sx); min1 = longint'(ex);
        end else begin
          maj0 = longint'(sx); maj1 = longint'(ex); min0 = longint'(sy); min1 = longint'(ey);
        end
        if (maj1 < maj0) begin
          hold = maj0; maj0 = maj1; maj1 = hold;
          hold = min0; min0 = min1; min1 = hold;
        end
        major_pos   = maj0;
        major_end   = maj1;
        minor_acc   = min0 * FIX_ONE;
        // Signed division truncates toward zero, as the slope divider does.
        minor_inc   = ((min1 - min0) * FIX_ONE) / (maj1 - maj0);
        line_active = 1'b1;
        return 1'b0;
      end
      if (!line_active) return 1'b0;
      w         = (line_width == 0) ? 1 : line_width;
      minor     = minor_acc / FIX_ONE;
      offset    = longint'(span_index) - longint'(w / 2);
      last_span = (span_index + 1 >= w);
      pix.done  = last_span && (major_pos == major_end);
      if (steep_axis) begin
        px = minor + offset;
        py = major_pos;
      end else begin
        px = major_pos;
        py = minor + offset;
      end
      pix.x = px[COORD_BITS:0];
      pix.y = py[COORD_BITS:0];
      expected_pixels.push_back(pix);
      if (last_span) begin
        span_index = 0;
        if (pix.done) begin
          line_active = 1'b0;
        end else begin
          major_pos++;
          minor_acc += minor_inc;
        end
      end else begin
        span_index++;
      end
      return 1'b1;
    endfunction

    task check_pixel(pix_t x, pix_t y, logic done);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) with none expected", x, y));
        return;
      end
      want = expected_pixels.pop_front();
      if (x !== want.x) report_mismatch($sformatf("pixel_x %0d, expected %0d", x, want.x));
      if (y !== want.y) report_mismatch($sformatf("pixel_y %0d, expected %0d", y, want.y));
      if (done !== want.done)
        report_mismatch($sformatf("line_done %0b, expected %0b at (%0d,%0d)",
                                  done, want.done, want.x, want.y));
    endtask
  endclass

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  width_t cfg_wdata;

  tdr_in_if  #(.COORD_BITS(COORD_BITS)) in_if ();
  tdr_out_if #(.COORD_BITS(COORD_BITS)) out_if ();

  raster_scoreboard sb = new;
  int               taken_requests;
  bit               idle_enable;
  bit               hold_request;

  thick_dda_line_rasterizer #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #3_000_000;
    $display("tb_thick_dda_line_rasterizer failed");
    $finish;
  end

  // Ignored advances are not counted, so the random part is sized by real work.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      if (sb.take_request(in_if.operation, in_if.start_x, in_if.start_y, in_if.end_x,
                          in_if.end_y) || in_if.operation == tdr_pkg::OP_START)
        taken_requests++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_pixel(out_if.pixel_x, out_if.pixel_y, out_if.line_done);
  end

  initial begin : pixel_sink
    bit hold_served;
    hold_served = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_served) begin
        // A long hold-off lets the block fill up and stall the request channel.
        hold_served = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic coord_t coord_near(coord_t base, int reach);
    longint v;
    v = longint'(base) + longint'($urandom_range(0, 2 * reach)) - reach;
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  task automatic send_req(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.start_x   <= sx;
    in_if.start_y   <= sy;
    in_if.end_x     <= ex;
    in_if.end_y     <= ey;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Endpoint fields of an advance are ignored, so they carry random bits.
  task automatic send_advances(int n);
    repeat (n) send_req(tdr_pkg::OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(),
                        rand_coord());
  endtask

  task automatic drain_pixels();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(width_t w);
    drain_pixels();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.line_width = w;
  endtask

  task automatic draw_random_line(int reach);
    coord_t x0, y0, x1, y1;
    longint adx, ady;
    int     pixels, count;
    x0  = rand_coord();
    y0  = rand_coord();
    x1  = coord_near(x0, reach);
    y1  = coord_near(y0, reach);
    adx = longint'(x1) - longint'(x0);
    ady = longint'(y1) - longint'(y0);
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    if (adx == 0 && ady == 0)
      pixels = 0;
    else
      pixels = int'(((adx > ady ? adx : ady) + 1) *
                    ((sb.line_width == 0) ? 1 : sb.line_width));
    count = pixels;
    // Some lines are cut short so that the next start drops them.
    if ($urandom_range(0, 4) == 0) count = $urandom_range(0, pixels);
    if (count > MAX_ADVANCES) count = MAX_ADVANCES;
    if ($urandom_range(0, 2) == 0) count += $urandom_range(1, 2);
    send_req(tdr_pkg::OP_START, x0, y0, x1, y1);
    send_advances(count);
  endtask

  task automatic run_random(int quota);
    int     first;
    coord_t cx, cy;
    first = taken_requests;
    while (taken_requests - first < quota) begin
      case ($urandom_range(0, 19))
        0, 1: send_req($urandom_range(0, 1) ? tdr_pkg::OP_ADVANCE : tdr_pkg::OP_START,
                       rand_coord(), rand_coord(), rand_coord(), rand_coord());
        2: begin
          cx = rand_coord();
          cy = rand_coord();
          send_req(tdr_pkg::OP_START, cx, cy, cx, cy);
          send_advances(1);
        end
        3: drain_pixels();
        4, 5: draw_random_line(2 * int'(COORD_MAX) + 1);
        default: draw_random_line($urandom_range(1, 6));
      endcase
    end
  endtask

  initial begin : stimulus
    int phase_width [8];
    int phase;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_if.valid     <= 1'b0;
    in_if.operation <= tdr_pkg::OP_START;
    in_if.start_x   <= '0;
    in_if.start_y   <= '0;
    in_if.end_x     <= '0;
    in_if.end_y     <= '0;
    idle_enable  = 1'b1;
    hold_request = 1'b0;
    sb.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset width of one pixel.
    send_req(tdr_pkg::OP_ADVANCE, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    send_req(tdr_pkg::OP_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_advances(2);
    send_req(tdr_pkg::OP_START, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_advances(2);
    send_req(tdr_pkg::OP_START, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_advances(2);
    send_req(tdr_pkg::OP_START, coord_t'(1), coord_t'(-3), coord_t'(-2), coord_t'(-3));
    send_advances(5);
    send_req(tdr_pkg::OP_START, coord_t'(4), coord_t'(3), coord_t'(4), coord_t'(1));
    send_advances(3);
    send_req(tdr_pkg::OP_START, coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(-2));
    send_advances(2);
    send_req(tdr_pkg::OP_START, coord_t'(6), coord_t'(6), coord_t'(6), coord_t'(6));
    send_advances(1);

    phase_width = '{63, 0, 2, 1, 32, $urandom_range(1, 63), $urandom_range(0, 63), 3};
    for (phase = 0; phase < 8; phase++) begin
      idle_enable = (phase != 4) && (phase != 7);
      set_width(width_t'(phase_width[phase]));
      if (phase == 2) hold_request = 1'b1;
      run_random(125);
    end
    drain_pixels();

    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("tb_thick_dda_line_rasterizer passed");
    end else begin
      $display("tb_thick_dda_line_rasterizer failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tdr_pkg.sv
rtl/core/tdr_chan_if.sv
rtl/core/thick_dda_line_rasterizer.sv
dv/tb_thick_dda_line_rasterizer.sv
